// ===== src/psg_pkg.sv =====
// psg_pkg: types, constants and sequencer states of the speed profile generator
// no dependencies; imported by piecewise_speed_profile_generator
`default_nettype none

package psg_pkg;

	localparam int MAX_SEGMENTS = 8;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;
	localparam logic [22:0] DECEL_MIN = 23'd6554;
	localparam logic [22:0] DECEL_RESET = 23'd196608;
	localparam logic [32:0] ONE_SECOND = 33'd65536;

	// configuration register indexes
	localparam logic [1:0] REG_PROFILE_MODE = 2'd0;
	localparam logic [1:0] REG_MAX_DECEL = 2'd1;
	localparam logic [1:0] REG_INITIAL_SPEED = 2'd2;
	localparam logic [1:0] REG_SEGMENT_COUNT = 2'd3;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// profile modes
	localparam logic MODE_VELOCITY = 1'b0;
	localparam logic MODE_ACCEL = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [2:0]         seg_index;
		logic [31:0]        seg_start;
		logic [31:0]        seg_end;
		logic               seg_until_end;
		logic signed [23:0] seg_value;
		logic [31:0]        now_time;
		logic [16:0]        step_size;
		logic               in_stop_zone;
	} psg_in_t;

	typedef struct packed {
		logic [23:0] desired_speed;
		logic        segment_found;
	} psg_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MULT,
		ST_FINISH
	} psg_state_t;

endpackage

`default_nettype wire

// ===== src/piecewise_speed_profile_generator.sv =====
// piecewise_speed_profile_generator: segment table, scan sequencer and shared multiplier
// depends on psg_pkg
// load items and ticks with no segments: result strobe in the cycle after the transfer
// ticks: result after the table scan (one entry per cycle, up to segment_count entries,
// at most eight), then the shared multiplier in ST_MULT and saturation in ST_FINISH;
// busy meanwhile
// the receiver cannot stall: result_valid is a single-cycle strobe
// reset: registers to defaults, speed and last time to zero, segment table undefined
`default_nettype none

module piecewise_speed_profile_generator
	import psg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire psg_in_t     item,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	output logic             result_valid,
	output psg_out_t         result
);

	// configuration
	logic              profile_mode_q;
	logic [22:0]       decel_cfg_q;
	logic [23:0]       initial_speed_q;
	logic [3:0]        segment_count_q;

	// segment table
	logic [31:0]        start_table_q [MAX_SEGMENTS];
	logic [31:0]        end_table_q [MAX_SEGMENTS];
	logic signed [23:0] value_table_q [MAX_SEGMENTS];
	logic               open_table_q [MAX_SEGMENTS];

	psg_state_t         state_q, state_d;
	psg_in_t            item_q;
	logic [IDX_W-1:0]   idx_q;
	logic               found_q;
	logic signed [23:0] value_q;
	logic signed [42:0] prod_q;
	logic [23:0]        speed_now_q;
	logic [31:0]        prev_time_q;
	logic               result_valid_q;
	psg_out_t           result_q;

	logic               accept;
	logic [CNT_W-1:0]   cnt_eff;
	logic [22:0]        decel_eff;
	logic               scan_stop, scan_active, scan_last;
	logic signed [32:0] dt_full;
	logic signed [33:0] dt_twice;
	logic               dt_guard;
	logic [16:0]        dt_use;
	logic signed [23:0] value_eff;
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [26:0] scaled;
	logic signed [27:0] sum;
	logic [23:0]        speed_sat;
	logic [23:0]        target;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	assign cnt_eff = (segment_count_q > 4'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
		: CNT_W'(segment_count_q);
	assign decel_eff = (decel_cfg_q < DECEL_MIN) ? DECEL_MIN : decel_cfg_q;

	// one table entry per scan cycle
	assign scan_stop = item_q.now_time < start_table_q[idx_q];
	assign scan_active = open_table_q[idx_q] || (item_q.now_time < end_table_q[idx_q]);
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_eff;

	// guarded time step for acceleration mode
	assign dt_full = $signed({1'b0, item_q.now_time}) - $signed({1'b0, prev_time_q});
	assign dt_twice = {dt_full, 1'b0};
	assign dt_guard = (dt_twice < $signed({17'd0, item_q.step_size}))
		|| (dt_full > $signed(ONE_SECOND));
	assign dt_use = dt_guard ? item_q.step_size : dt_full[16:0];

	assign value_eff = (item_q.in_stop_zone && (value_q > 24'sd0))
		? -$signed({1'b0, decel_eff}) : value_q;

	// shared multiplier operands
	always_comb begin
		if (profile_mode_q == MODE_VELOCITY) begin
			mul_a = $signed({2'b00, decel_eff});
			mul_b = $signed({1'b0, item_q.step_size});
		end else begin
			mul_a = $signed({value_eff[23], value_eff});
			mul_b = $signed({1'b0, dt_use});
		end
	end

	// arithmetic shift of the product is the floor of the Q16 scaling
	assign scaled = prod_q[42:16];

	always_comb begin
		if (profile_mode_q == MODE_VELOCITY) begin
			sum = $signed({4'd0, speed_now_q}) - $signed({scaled[26], scaled});
		end else begin
			sum = $signed({4'd0, speed_now_q}) + $signed({scaled[26], scaled});
		end
		if (sum < 28'sd0) begin
			speed_sat = '0;
		end else if (sum > $signed({4'd0, SPEED_MAX})) begin
			speed_sat = SPEED_MAX;
		end else begin
			speed_sat = sum[23:0];
		end
	end

	assign target = (value_q > 24'sd0) ? $unsigned(value_q) : 24'd0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.opcode == OP_TICK) && (cnt_eff != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_stop || scan_last) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_mode_q <= MODE_VELOCITY;
			decel_cfg_q <= DECEL_RESET;
			initial_speed_q <= '0;
			segment_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROFILE_MODE:  profile_mode_q <= cfg_data[0];
				REG_MAX_DECEL:     decel_cfg_q <= cfg_data[22:0];
				REG_INITIAL_SPEED: initial_speed_q <= cfg_data;
				REG_SEGMENT_COUNT: segment_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// table writes on a load transfer
	always_ff @(posedge clk) begin
		if (accept && (item.opcode == OP_LOAD) && (32'(item.seg_index) < MAX_SEGMENTS)) begin
			start_table_q[IDX_W'(item.seg_index)] <= item.seg_start;
			end_table_q[IDX_W'(item.seg_index)] <= item.seg_end;
			value_table_q[IDX_W'(item.seg_index)] <= item.seg_value;
			open_table_q[IDX_W'(item.seg_index)] <= item.seg_until_end;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			value_q <= '0;
		end else if ((state_q == ST_SCAN) && !scan_stop && scan_active) begin
			value_q <= value_table_q[idx_q];
		end
		if (state_q == ST_MULT) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// speed state, scan control and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_now_q <= '0;
			prev_time_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					if (accept && (item.opcode == OP_LOAD)) begin
						speed_now_q <= initial_speed_q;
						prev_time_q <= '0;
						result_q.desired_speed <= initial_speed_q;
						result_q.segment_found <= 1'b0;
						result_valid_q <= 1'b1;
					end else if (accept && (cnt_eff == '0)) begin
						result_q <= '0;
						result_valid_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (!scan_stop && scan_active) begin
						found_q <= 1'b1;
					end
					if (!scan_stop && !scan_last) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_MULT: ;
				ST_FINISH: begin
					result_valid_q <= 1'b1;
					result_q.segment_found <= found_q;
					if (profile_mode_q == MODE_ACCEL) begin
						speed_now_q <= speed_sat;
						prev_time_q <= item_q.now_time;
						result_q.desired_speed <= speed_sat;
					end else if (item_q.in_stop_zone) begin
						speed_now_q <= speed_sat;
						result_q.desired_speed <= (target > speed_sat) ? speed_sat : target;
					end else begin
						speed_now_q <= target;
						result_q.desired_speed <= target;
					end
				end
				default: ;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// a load always answers in the next cycle
	a_load_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.opcode == OP_LOAD)) |=> result_valid)
		else $error("load transfer without result strobe");

	// a result is only shown once the sequencer is back in idle
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// the scan never reads past the segments in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(idx_q) < cnt_eff))
		else $error("scan index beyond segment count");

endmodule

`default_nettype wire
